### src/pdd_pkg.sv
// Shared types and constants for the pointer drag detector.
// Field widths, stream packing widths and the per-tick record types.
// No dependencies.
`default_nettype none

package pdd_pkg;

  // Coordinate and delta widths
  localparam int COORD_BITS = 16;
  localparam int DELTA_W    = COORD_BITS + 1;

  // Buttons: bit index of the left button inside the level vector
  localparam int BTN_W    = 3;
  localparam int BTN_LEFT = 0;

  // Drag threshold register
  localparam int          THR_W    = 12;
  localparam int          THR_SQ_W = 2 * THR_W;
  localparam int          THR_MAX  = (1 << THR_W) - 1;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

  // Magnitude width: wide enough for a delta and for THR_MAX + 1
  localparam int MAG_W = (DELTA_W > THR_W + 1) ? DELTA_W : THR_W + 1;

  // Stream packing, rounded up to whole bytes
  localparam int IN_W       = BTN_W + 2 * COORD_BITS;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = 3 * BTN_W + 4 * DELTA_W + 1;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // One poll tick
  typedef struct packed {
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
    logic [BTN_W-1:0]             buttons;
  } pdd_item_t;

  // Tracking state carried from tick to tick
  typedef struct packed {
    logic [BTN_W-1:0]             prev_buttons;
    logic signed [COORD_BITS-1:0] last_x;
    logic signed [COORD_BITS-1:0] last_y;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic                         drag_active;
  } pdd_state_t;

  // One result record, members listed from the top bit down
  typedef struct packed {
    logic signed [DELTA_W-1:0] drag_dy;
    logic signed [DELTA_W-1:0] drag_dx;
    logic                      dragging;
    logic signed [DELTA_W-1:0] move_dy;
    logic signed [DELTA_W-1:0] move_dx;
    logic [BTN_W-1:0]          released;
    logic [BTN_W-1:0]          pressed;
    logic [BTN_W-1:0]          down;
  } pdd_result_t;

endpackage

`default_nettype wire

### src/pdd_core.sv
// Per-tick evaluation: button edges, motion, drag start test and drag offset.
// Pure combinational step from the current state to the next state.
// Depends on pdd_pkg.
`default_nettype none

module pdd_core (
  input  pdd_pkg::pdd_item_t                 item,
  input  pdd_pkg::pdd_state_t                state,
  input  logic [pdd_pkg::THR_SQ_W-1:0]       thr_sq,
  output pdd_pkg::pdd_result_t               result,
  output pdd_pkg::pdd_state_t                state_next
);
  import pdd_pkg::*;

  logic [BTN_W-1:0]          pressed;
  logic [BTN_W-1:0]          released;
  logic signed [COORD_BITS-1:0] sx;
  logic signed [COORD_BITS-1:0] sy;
  logic signed [DELTA_W-1:0] mdx;
  logic signed [DELTA_W-1:0] mdy;
  logic signed [DELTA_W-1:0] odx;
  logic signed [DELTA_W-1:0] ody;
  logic [DELTA_W-1:0]        abs_x;
  logic [DELTA_W-1:0]        abs_y;
  logic [MAG_W-1:0]          mag_x;
  logic [MAG_W-1:0]          mag_y;
  logic [THR_SQ_W-1:0]       sq_x;
  logic [THR_SQ_W-1:0]       sq_y;
  logic [THR_SQ_W:0]         dist_sq;
  logic                      far;
  logic                      beyond;
  logic                      drag_next;

  // Sign extend a coordinate to delta width
  function automatic logic signed [DELTA_W-1:0] sext(input logic signed [COORD_BITS-1:0] v);
    sext = {v[COORD_BITS-1], v};
  endfunction

  // Button edges
  assign pressed  = item.buttons & ~state.prev_buttons;
  assign released = ~item.buttons & state.prev_buttons;

  // Motion since the previous tick
  assign mdx = sext(item.x) - sext(state.last_x);
  assign mdy = sext(item.y) - sext(state.last_y);

  // A left press latches the start point before the offset is taken
  assign sx  = pressed[BTN_LEFT] ? item.x : state.start_x;
  assign sy  = pressed[BTN_LEFT] ? item.y : state.start_y;
  assign odx = sext(item.x) - sext(sx);
  assign ody = sext(item.y) - sext(sy);

  // Offset magnitudes
  assign abs_x = odx[DELTA_W-1] ? DELTA_W'(-odx) : DELTA_W'(odx);
  assign abs_y = ody[DELTA_W-1] ? DELTA_W'(-ody) : DELTA_W'(ody);
  assign mag_x = MAG_W'(abs_x);
  assign mag_y = MAG_W'(abs_y);

  // Squared distance against squared threshold; large offsets always pass
  assign far     = (mag_x > MAG_W'(THR_MAX)) || (mag_y > MAG_W'(THR_MAX));
  assign sq_x    = THR_SQ_W'(mag_x[THR_W-1:0]) * THR_SQ_W'(mag_x[THR_W-1:0]);
  assign sq_y    = THR_SQ_W'(mag_y[THR_W-1:0]) * THR_SQ_W'(mag_y[THR_W-1:0]);
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign beyond  = far || (dist_sq > {1'b0, thr_sq});

  // Drag holds while left is down, ends on release
  assign drag_next = item.buttons[BTN_LEFT] & (state.drag_active | beyond);

  // Result record
  always_comb begin
    result.down     = item.buttons;
    result.pressed  = pressed;
    result.released = released;
    result.move_dx  = mdx;
    result.move_dy  = mdy;
    result.dragging = drag_next;
    result.drag_dx  = drag_next ? odx : '0;
    result.drag_dy  = drag_next ? ody : '0;
  end

  // Next state
  always_comb begin
    state_next.prev_buttons = item.buttons;
    state_next.last_x       = item.x;
    state_next.last_y       = item.y;
    state_next.start_x      = sx;
    state_next.start_y      = sy;
    state_next.drag_active  = drag_next;
  end

endmodule

`default_nettype wire

### src/pointer_drag_detector.sv
// Pointer drag detector top level: stream ports, input and result registers,
// tracking state and drag threshold register.
// Depends on pdd_pkg and pdd_core.
//
// Usage:
//   s_* carries one poll tick per transfer (buttons and cursor position).
//   m_* returns one result per tick, in order: button levels and edges,
//   motion since the last tick, the dragging flag and the drag offset.
//   cfg_* writes the drag threshold; cfg_ready is always high and a write
//   is meant to land only while no tick is in flight.
// Timing:
//   A tick is held in the input register; the combinational step logic
//   then loads the result register, so m_tvalid rises once the tick has
//   passed through the input register and then the result register.
//   One tick per cycle is sustained while m_tready stays high; the state
//   update is a registered loop through the squared distance compare.
// Reset (rst, synchronous): both registers empty, tracking state zero,
//   threshold 5. A stall on m_tready holds the result; one more tick can
//   still enter the input register before s_tready drops.
`default_nettype none

module pointer_drag_detector (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata from bit 0: buttons[2:0], cursor_x[15:0], cursor_y[15:0], zero pad
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pdd_pkg::IN_TDATA_W-1:0]   s_tdata,
  // m_tdata from bit 0: button_down[2:0], button_pressed[2:0],
  // button_released[2:0], move_dx[16:0], move_dy[16:0], dragging,
  // drag_dx[16:0], drag_dy[16:0], zero pad
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pdd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // drag_threshold write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pdd_pkg::THR_W-1:0]        cfg_data
);
  import pdd_pkg::*;

  logic                 in_valid;
  pdd_item_t            in_item;
  logic                 out_valid;
  pdd_result_t          out_res;
  pdd_state_t           st;
  pdd_state_t           st_next;
  pdd_result_t          res_next;
  logic [THR_W-1:0]     drag_threshold;
  logic [THR_SQ_W-1:0]  thr_sq;
  logic                 advance;
  logic                 load;

  // Handshake control
  assign advance   = !out_valid || m_tready;
  assign load      = in_valid && advance;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Threshold register, squared on write
  always_ff @(posedge clk) begin
    if (rst) begin
      drag_threshold <= THR_RESET;
      thr_sq         <= THR_SQ_W'(THR_RESET) * THR_SQ_W'(THR_RESET);
    end else if (cfg_valid) begin
      drag_threshold <= cfg_data;
      thr_sq         <= THR_SQ_W'(cfg_data) * THR_SQ_W'(cfg_data);
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[IN_W-1:0];
    end
  end

  // Step logic
  pdd_core u_core (
    .item       (in_item),
    .state      (st),
    .thr_sq     (thr_sq),
    .result     (res_next),
    .state_next (st_next)
  );

  // Tracking state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        st <= st_next;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
    if (load) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_res);

`ifndef SYNTHESIS
  // A reported drag always comes with the left button held
  a_drag_needs_left: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.dragging) |-> out_res.down[BTN_LEFT])
    else $error("dragging reported without left button");

  // Drag offset is zero whenever no drag is reported
  a_idle_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.dragging) |-> (out_res.drag_dx == '0 && out_res.drag_dy == '0))
    else $error("drag offset nonzero outside a drag");

  // The stored drag flag tracks the last result produced
  a_state_matches_result: assert property (@(posedge clk) disable iff (rst)
    (load) |=> (out_res.dragging == st.drag_active && out_res.down == st.prev_buttons))
    else $error("tracking state out of step with result");

  // Threshold square stays consistent with the threshold register
  a_thr_sq: assert property (@(posedge clk) disable iff (rst)
    $rose(cfg_valid) |=> (thr_sq == THR_SQ_W'(drag_threshold) * THR_SQ_W'(drag_threshold)))
    else $error("threshold square out of step");
`endif

endmodule

`default_nettype wire
